/* hdl/lkv_pkg.sv */
// lkv_pkg: shared constants, types and sequencer states for the LRU key-value cache.
// No dependencies; imported by every module under hdl/.
package lkv_pkg;

   localparam int MAX_ENTRIES = 16;
   localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int THR_W       = IDX_W + 1;
   localparam int CAP_W       = 5;
   localparam int DATA_W      = 32;
   localparam int CMP_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(16);
   localparam logic [DATA_W-1:0] MISS_VALUE = '1;
   localparam logic [DATA_W-1:0] PUT_VALUE  = '0;
   localparam logic              OP_GET     = 1'b0;
   localparam logic              OP_PUT     = 1'b1;

   typedef logic [IDX_W-1:0] idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPLY,
      ST_UPDATE,
      ST_DONE
   } state_type;

   // sequencer strobes towards the datapath
   typedef struct packed {
      logic    idle;
      logic    accept;
      logic    scan;
      logic    apply;
      logic    update;
      logic    finish;
      idx_type idx;
   } ctrl_type;

   // write side of the entry store
   typedef struct packed {
      logic              key_we;
      logic              val_we;
      logic              set_valid;
      logic              clr_valid;
      logic              rank_we;
      idx_type           slot;
      idx_type           victim;
      idx_type           rank_idx;
      logic [DATA_W-1:0] key;
      logic [DATA_W-1:0] val;
      idx_type           rank;
   } store_wr_type;

   // flags from the shared compare unit
   typedef struct packed {
      logic match;
      logic older;
      logic younger;
   } cmp_type;

endpackage

/* hdl/lru_key_value_cache.sv */
// lru_key_value_cache: fully associative LRU key-value store, one entry per cycle.
// Each word takes a scan pass, then apply, then a rank pass on a get hit or any put;
//   a get miss skips the rank pass. The single shared comparator walks the entry
//   table one entry at a time, so a new request is taken only once the last word
//   has been handed off: req_ready is high only in the idle state.
// Reset (synchronous, active high): all entries invalid, count zero, capacity 16.
module lru_key_value_cache (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_operation,
   input  logic signed [lkv_pkg::DATA_W-1:0]  req_key,
   input  logic signed [lkv_pkg::DATA_W-1:0]  req_value,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_found,
   output logic signed [lkv_pkg::DATA_W-1:0]  rsp_value_out,
   output logic                               rsp_evicted,
   // capacity register
   input  logic                               csr_we,
   input  logic [lkv_pkg::CAP_W-1:0]          csr_wdata
);
   import lkv_pkg::*;

   ctrl_type          ctrl;
   store_wr_type      wr;
   cmp_type           flags;

   logic [DATA_W-1:0] rd_key, rd_val;
   logic              rd_valid;
   idx_type           rd_rank;

   // latched request word
   logic              op_ff;
   logic [DATA_W-1:0] key_ff, val_ff;

   // scan accumulators: hit slot, least recent entry, first free slot
   logic              hit_ff, vic_any_ff, free_any_ff;
   idx_type           slot_ff, hrank_ff, vic_ff, vrank_ff, free_ff;
   logic [DATA_W-1:0] hval_ff;
   logic [THR_W-1:0]  thr_ff;

   logic [CNT_W-1:0]  count_ff;
   logic [CAP_W-1:0]  cap_ff;

   // result held between apply and hand-off
   logic              res_found_ff, res_evicted_ff;
   logic [DATA_W-1:0] res_value_ff;

   logic              rsp_valid_ff, rsp_found_ff, rsp_evicted_ff;
   logic [DATA_W-1:0] rsp_value_ff;

   logic [CMP_W-1:0]  eff_cap;
   logic              full, drop, put_miss;
   idx_type           ins_slot, new_rank;

   // ------------------------------------------------------------------
   // sequencer, shared comparator, entry table
   // ------------------------------------------------------------------
   lkv_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .rsp_free    (!rsp_valid_ff || rsp_ready),
      .need_update (hit_ff || op_ff),
      .ctrl        (ctrl)
   );

   lkv_cmp_unit u_cmp (
      .entry_key   (rd_key),
      .req_key     (key_ff),
      .entry_valid (rd_valid),
      .entry_rank  (rd_rank),
      .victim_rank (vrank_ff),
      .victim_any  (vic_any_ff),
      .threshold   (thr_ff),
      .flags       (flags)
   );

   lkv_store u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_idx   (ctrl.idx),
      .wr       (wr),
      .rd_key   (rd_key),
      .rd_val   (rd_val),
      .rd_valid (rd_valid),
      .rd_rank  (rd_rank)
   );

   // ------------------------------------------------------------------
   // decisions taken in the apply cycle
   // ------------------------------------------------------------------
   // capacity zero acts as one, anything above the table size saturates
   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = CMP_W'(1);
      end else if (CMP_W'(cap_ff) > CMP_W'(MAX_ENTRIES)) begin
         eff_cap = CMP_W'(MAX_ENTRIES);
      end else begin
         eff_cap = CMP_W'(cap_ff);
      end
   end

   assign full     = CMP_W'(count_ff) >= eff_cap;
   assign put_miss = (op_ff == OP_PUT) && !hit_ff;
   assign drop     = put_miss && full;

   // new key goes to the lowest free slot once the victim is gone
   always_comb begin
      if (drop && !(free_any_ff && (free_ff < vic_ff))) begin
         ins_slot = vic_ff;
      end else begin
         ins_slot = free_ff;
      end
   end

   // rank pass: the touched slot becomes most recent, younger valid entries age
   always_comb begin
      if (ctrl.idx == slot_ff) begin
         new_rank = '0;
      end else if (rd_valid && flags.younger) begin
         new_rank = rd_rank + 1'b1;
      end else begin
         new_rank = rd_rank;
      end
   end

   always_comb begin
      wr           = '0;
      wr.slot      = hit_ff ? slot_ff : ins_slot;
      wr.victim    = vic_ff;
      wr.key       = key_ff;
      wr.val       = val_ff;
      wr.key_we    = ctrl.apply && put_miss;
      wr.set_valid = ctrl.apply && put_miss;
      wr.val_we    = ctrl.apply && (op_ff == OP_PUT);
      wr.clr_valid = ctrl.apply && drop;
      wr.rank_we   = ctrl.update;
      wr.rank_idx  = ctrl.idx;
      wr.rank      = new_rank;
   end

   // ------------------------------------------------------------------
   // request word and scan accumulators (payload, no reset)
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         op_ff  <= req_operation;
         key_ff <= req_key;
         val_ff <= req_value;
      end
      if (ctrl.scan) begin
         if (flags.match && !hit_ff) begin
            slot_ff  <= ctrl.idx;
            hrank_ff <= rd_rank;
            hval_ff  <= rd_val;
         end
         if (flags.older) begin
            vic_ff   <= ctrl.idx;
            vrank_ff <= rd_rank;
         end
         if (!rd_valid && !free_any_ff) begin
            free_ff <= ctrl.idx;
         end
      end
      if (ctrl.apply) begin
         slot_ff        <= hit_ff ? slot_ff : ins_slot;
         thr_ff         <= hit_ff ? {1'b0, hrank_ff} : THR_W'(MAX_ENTRIES);
         res_found_ff   <= hit_ff;
         res_evicted_ff <= drop;
         if (op_ff == OP_PUT) begin
            res_value_ff <= PUT_VALUE;
         end else begin
            res_value_ff <= hit_ff ? hval_ff : MISS_VALUE;
         end
      end
      if (ctrl.finish) begin
         rsp_found_ff   <= res_found_ff;
         rsp_evicted_ff <= res_evicted_ff;
         rsp_value_ff   <= res_value_ff;
      end
   end

   // ------------------------------------------------------------------
   // control state
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff       <= 1'b0;
         vic_any_ff   <= 1'b0;
         free_any_ff  <= 1'b0;
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ctrl.accept) begin
            hit_ff      <= 1'b0;
            vic_any_ff  <= 1'b0;
            free_any_ff <= 1'b0;
         end else if (ctrl.scan) begin
            if (flags.match) hit_ff      <= 1'b1;
            if (flags.older) vic_any_ff  <= 1'b1;
            if (!rd_valid)   free_any_ff <= 1'b1;
         end
         // a drop and an insert cancel out in the count
         if (ctrl.apply && put_miss && !drop) begin
            count_ff <= count_ff + 1'b1;
         end
         if (csr_we) begin
            cap_ff <= csr_wdata;
         end
         if (ctrl.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_ready     = ctrl.idle;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_evicted   = rsp_evicted_ff;
   assign rsp_value_out = rsp_value_ff;

   // ------------------------------------------------------------------
   // checks
   // ------------------------------------------------------------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ENTRIES))
      else $error("entry count above table size");

   a_evict_only_on_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_evicted && rsp_found))
      else $error("eviction reported on a hit");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while a word is in progress");

   a_drop_needs_victim: assert property (@(posedge clock) disable iff (reset)
      (ctrl.apply && drop) |-> vic_any_ff)
      else $error("eviction with no valid entry");

endmodule

/* hdl/lkv_store.sv */
// lkv_store: entry table (keys, values, valid bits, recency ranks), one read index.
// Depends on lkv_pkg.
module lkv_store (
   input  logic                        clock,
   input  logic                        reset,
   input  lkv_pkg::idx_type            rd_idx,
   input  lkv_pkg::store_wr_type       wr,
   output logic [lkv_pkg::DATA_W-1:0]  rd_key,
   output logic [lkv_pkg::DATA_W-1:0]  rd_val,
   output logic                        rd_valid,
   output lkv_pkg::idx_type            rd_rank
);
   import lkv_pkg::*;

   logic [DATA_W-1:0]      key_ff   [MAX_ENTRIES];
   logic [DATA_W-1:0]      val_ff   [MAX_ENTRIES];
   idx_type                rank_ff  [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] valid_ff;

   always_ff @(posedge clock) begin
      if (wr.key_we) begin
         key_ff[wr.slot] <= wr.key;
      end
      if (wr.val_we) begin
         val_ff[wr.slot] <= wr.val;
      end
      if (wr.rank_we) begin
         rank_ff[wr.rank_idx] <= wr.rank;
      end
   end

   // set after clear: an insert into the slot just dropped leaves it valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (wr.clr_valid) begin
            valid_ff[wr.victim] <= 1'b0;
         end
         if (wr.set_valid) begin
            valid_ff[wr.slot] <= 1'b1;
         end
      end
   end

   assign rd_key   = key_ff[rd_idx];
   assign rd_val   = val_ff[rd_idx];
   assign rd_rank  = rank_ff[rd_idx];
   assign rd_valid = valid_ff[rd_idx];

endmodule

/* hdl/lkv_cmp_unit.sv */
// lkv_cmp_unit: shared key/rank comparator used on one entry per cycle.
// Depends on lkv_pkg.
module lkv_cmp_unit (
   input  logic [lkv_pkg::DATA_W-1:0] entry_key,
   input  logic [lkv_pkg::DATA_W-1:0] req_key,
   input  logic                       entry_valid,
   input  lkv_pkg::idx_type           entry_rank,
   input  lkv_pkg::idx_type           victim_rank,
   input  logic                       victim_any,
   input  logic [lkv_pkg::THR_W-1:0]  threshold,
   output lkv_pkg::cmp_type           flags
);
   import lkv_pkg::*;

   always_comb begin
      flags.match   = entry_valid && (entry_key == req_key);
      flags.older   = entry_valid && (!victim_any || (entry_rank > victim_rank));
      flags.younger = {1'b0, entry_rank} < threshold;
   end

endmodule

/* hdl/lkv_ctrl.sv */
// lkv_ctrl: sequencer for scan / apply / rank update, with the entry index counter.
// Depends on lkv_pkg.
module lkv_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              rsp_free,
   input  logic              need_update,
   output lkv_pkg::ctrl_type ctrl
);
   import lkv_pkg::*;

   state_type state_ff, state_in;
   idx_type   idx_ff, idx_in;
   logic      last;

   assign last = (idx_ff == IDX_W'(MAX_ENTRIES - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (last) state_in = ST_APPLY;
         end
         ST_APPLY: begin
            state_in = need_update ? ST_UPDATE : ST_DONE;
         end
         ST_UPDATE: begin
            if (last) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctrl        = '0;
      ctrl.idx    = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            ctrl.idle   = 1'b1;
            ctrl.accept = req_valid;
         end
         ST_SCAN:   ctrl.scan   = 1'b1;
         ST_APPLY:  ctrl.apply  = 1'b1;
         ST_UPDATE: ctrl.update = 1'b1;
         ST_DONE:   ctrl.finish = rsp_free;
         default:   ctrl.idle   = 1'b0;
      endcase
   end

   always_comb begin
      idx_in = idx_ff;
      if (ctrl.accept || ctrl.apply) begin
         idx_in = '0;
      end else if (ctrl.scan || ctrl.update) begin
         idx_in = last ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule
